// ----- sv/m4ta_pkg.sv -----
// Package for the 4x4 matrix transform accumulator: item structs, function codes, sizes.
// No dependencies.
`timescale 1ns / 1ps
package m4ta_pkg;
  localparam int DIM = 4;
  localparam int CELLS = 16;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_IDENT = 2'd1;
  localparam logic [1:0] FUNC_TRANS = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] elem_index;
    logic signed [31:0] elem_value;
    logic final_elem;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_index;
    logic signed [31:0] out_value;
    logic out_last;
    logic clipped;
  } out_item_t;
endpackage

// ----- sv/m4ta_cell.sv -----
// One multiply-accumulate cell of the product chain: multiplies an operand element
// by a current-matrix element and adds it into a 66-bit partial sum. Uses m4ta_pkg.
`timescale 1ns / 1ps
module m4ta_cell (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [65:0] acc
);
  import m4ta_pkg::*;
  logic signed [63:0] prod_r;
  logic               pv_r;
  logic signed [65:0] acc_r;

  // Register the product, then accumulate next cycle.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
    pv_r   <= en;
    if (clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + 66'(prod_r);
    end
  end
  assign acc = acc_r;
endmodule

// ----- sv/matrix4_transform_accumulator.sv -----
// Top level of the 4x4 matrix transform accumulator.
// Uses m4ta_pkg and m4ta_cell.
`timescale 1ns / 1ps
// A load item without the final mark stores its element and leaves the block idle.
// A final load runs the 4x4 product on a row of four MAC cells. Each output row i
// takes four k steps, one per cycle, then drain steps that accumulate the last
// product and store the saturated row. Then the new matrix is copied into the current one.
// Then 16 results stream out one per cycle, and no new item is accepted until the
// last result has left the ports. Identity and transpose skip the product and the
// copy and emit their 16 results right away. busy is high for the whole run.
// The receiver cannot stall: every result shows for
// exactly one cycle with out_valid high and must be taken then.
module matrix4_transform_accumulator #(
  parameter int FRAC_BITS = m4ta_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  m4ta_pkg::in_item_t  in_item,
  output logic                out_valid,
  output m4ta_pkg::out_item_t out_item
);
  import m4ta_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  state_r;
  logic [31:0] cur_r [CELLS];
  logic [31:0] opd_r [CELLS];
  logic [31:0] new_r [CELLS];
  logic        clip_r [CELLS];
  logic [1:0]  row_r;
  logic [2:0]  step_r;     // 0..3 issue, 4..5 drain
  logic [3:0]  emit_r;
  logic        upd_r;      // copy new into current at emit start
  logic        ov_r;
  out_item_t   oi_r;

  logic signed [65:0] acc [DIM];
  logic signed [31:0] ca  [DIM];
  logic signed [31:0] cb  [DIM];
  logic               cen;
  logic               cclr;

  assign cen  = (state_r == ST_MAC) && (step_r < 3'd4);
  assign cclr = (state_r == ST_MAC) && (step_r == 3'd0);

  // Cell j gets operand[k+4i] and current[j+4k].
  for (genvar j = 0; j < DIM; j++) begin : g_cell
    assign ca[j] = opd_r[{row_r, step_r[1:0]}];
    assign cb[j] = cur_r[{step_r[1:0], 2'(j)}];
    m4ta_cell u_cell (
      .clk(clk), .clr(cclr), .en(cen), .a(ca[j]), .b(cb[j]), .acc(acc[j])
    );
  end

  // Shift and saturate a finished sum.
  function automatic logic [32:0] sat(input logic signed [65:0] s);
    logic signed [65:0] sh;
    sh = s >>> FRAC_BITS;
    if (sh > 66'sh7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
    if (sh < -66'sh80000000) return {1'b1, 32'h80000000};
    return {1'b0, sh[31:0]};
  endfunction

  logic [32:0] sres [DIM];
  for (genvar j = 0; j < DIM; j++) begin : g_sat
    assign sres[j] = sat(acc[j]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      upd_r   <= 1'b0;
      for (int n = 0; n < CELLS; n++) begin
        cur_r[n]  <= (n % 5 == 0) ? (32'd1 << FRAC_BITS) : '0;
        opd_r[n]  <= '0;
        clip_r[n] <= 1'b0;
      end
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          // Hold off a new item while the last result is still on the ports.
          if (start && !busy) begin
            for (int n = 0; n < CELLS; n++) clip_r[n] <= 1'b0;
            emit_r <= '0;
            upd_r  <= 1'b0;
            case (in_item.func)
              FUNC_LOAD: begin
                opd_r[in_item.elem_index] <= in_item.elem_value;
                if (in_item.final_elem) begin
                  state_r <= ST_MAC;
                  row_r   <= '0;
                  step_r  <= '0;
                end
              end
              FUNC_IDENT: begin
                for (int n = 0; n < CELLS; n++)
                  cur_r[n] <= (n % 5 == 0) ? (32'd1 << FRAC_BITS) : '0;
                state_r <= ST_EMIT;
              end
              FUNC_TRANS: begin
                for (int i = 0; i < DIM; i++)
                  for (int j = 0; j < DIM; j++)
                    cur_r[i + DIM*j] <= cur_r[j + DIM*i];
                state_r <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_MAC: begin
          if (step_r == 3'd5) begin
            for (int j = 0; j < DIM; j++) begin
              new_r[{row_r, 2'(j)}]  <= sres[j][31:0];
              clip_r[{row_r, 2'(j)}] <= sres[j][32];
            end
            step_r <= '0;
            row_r  <= row_r + 2'd1;
            if (row_r == 2'd3) begin
              state_r <= ST_EMIT;
              upd_r   <= 1'b1;
            end
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_EMIT: begin
          if (upd_r) begin
            for (int n = 0; n < CELLS; n++) cur_r[n] <= new_r[n];
            upd_r <= 1'b0;
          end else begin
            ov_r <= 1'b1;
            oi_r.out_index <= emit_r;
            oi_r.out_value <= cur_r[emit_r];
            oi_r.out_last  <= (emit_r == 4'd15);
            oi_r.clipped   <= clip_r[emit_r];
            emit_r <= emit_r + 4'd1;
            if (emit_r == 4'd15) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while not busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_last) |=> !out_valid) else $error("result after last");
  a_mac_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (step_r <= 3'd5)) else $error("step overrun");
endmodule

// ----- tb/tb_matrix4_transform_accumulator.sv -----
// Self-checking testbench for the 4x4 matrix transform accumulator.
// Depends on m4ta_pkg and matrix4_transform_accumulator; a scoreboard class predicts results.
`timescale 1ns / 1ps
module tb_matrix4_transform_accumulator;
  import m4ta_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam longint CYCLE_LIMIT = 400000;

  // Predicts the block's matrix state and checks each emitted element in order.
  class matrix_scoreboard;
    logic [31:0] cur_mat [CELLS];
    logic [31:0] opnd_mat [CELLS];
    out_item_t pending_elems [$];
    int mismatches;

    function new();
      mismatches = 0;
      set_identity();
      foreach (opnd_mat[n]) opnd_mat[n] = '0;
    endfunction

    function void set_identity();
      foreach (cur_mat[n]) cur_mat[n] = (n % 5 == 0) ? (32'd1 << FRAC) : 32'd0;
    endfunction

    // Sum four products at full width, shift arithmetically, then saturate.
    function logic [31:0] dot_sat(int i, int j, output logic clip);
      logic signed [95:0] acc;
      logic signed [95:0] shifted;
      acc = '0;
      for (int k = 0; k < DIM; k++)
        acc += 96'(signed'(opnd_mat[k + DIM*i])) * 96'(signed'(cur_mat[j + DIM*k]));
      shifted = acc >>> FRAC;
      clip = 1'b1;
      if (shifted > 96'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (shifted < -96'sh80000000) return 32'h80000000;
      clip = 1'b0;
      return shifted[31:0];
    endfunction

    function void push_all(logic clips [CELLS]);
      out_item_t e;
      for (int n = 0; n < CELLS; n++) begin
        e.out_index = n[3:0];
        e.out_value = cur_mat[n];
        e.out_last  = (n == CELLS-1);
        e.clipped   = clips[n];
        pending_elems.push_back(e);
      end
    endfunction

    function void note_item(in_item_t it);
      logic [31:0] tmp [CELLS];
      logic clips [CELLS];
      foreach (clips[n]) clips[n] = 1'b0;
      case (it.func)
        FUNC_LOAD: begin
          opnd_mat[it.elem_index] = it.elem_value;
          if (it.final_elem) begin
            for (int i = 0; i < DIM; i++)
              for (int j = 0; j < DIM; j++)
                tmp[j + DIM*i] = dot_sat(i, j, clips[j + DIM*i]);
            cur_mat = tmp;
            push_all(clips);
          end
        end
        FUNC_IDENT: begin
          set_identity();
          push_all(clips);
        end
        FUNC_TRANS: begin
          for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
              tmp[i + DIM*j] = cur_mat[j + DIM*i];
          cur_mat = tmp;
          push_all(clips);
        end
        default: ;
      endcase
    endfunction

    function void check_elem(out_item_t got);
      out_item_t want;
      if (pending_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected element %p", got);
        return;
      end
      want = pending_elems.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic out_valid;
  in_item_t in_item = '0;
  out_item_t out_item;
  int idle_pct = 0;
  longint cycles = 0;
  matrix_scoreboard sb = new();

  always #1 clk = ~clk;

  matrix4_transform_accumulator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Check every strobed element at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_elem(out_item);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_matrix4_transform_accumulator: FAIL");
      $finish;
    end
  end

  // Random operand value: mostly moderate Q16.16, sometimes extremes or full range.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h40000))) - 32'sh20000;
    endcase
  endfunction

  // Hold start until accepted, with random idle gaps before it. Leave start high
  // after acceptance; the next item or an idle gap replaces it in the same step.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_fields(logic [1:0] f, int idx, logic [31:0] v, logic fin);
    in_item_t it;
    it.func = f; it.elem_index = idx[3:0]; it.elem_value = v; it.final_elem = fin;
    send_item(it);
  endtask

  // Load a full operand with random content; the final mark lands on the last element.
  task automatic send_matrix();
    for (int n = 0; n < CELLS; n++) send_fields(FUNC_LOAD, n, rand_value(), n == CELLS-1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity product, extremes that saturate both ways, transpose,
    // final mark on identity and transpose, unused selector, partial reload.
    for (int n = 0; n < CELLS; n++)
      send_fields(FUNC_LOAD, n, (n % 5 == 0) ? (32'd1 << FRAC) : 32'd0, n == CELLS-1);
    send_fields(FUNC_LOAD, 0, 32'h7FFFFFFF, 1'b0);
    send_fields(FUNC_LOAD, 1, 32'h80000000, 1'b0);
    send_fields(FUNC_LOAD, 15, 32'h7FFFFFFF, 1'b1);
    send_fields(FUNC_LOAD, 15, 32'h80000000, 1'b1);
    send_fields(FUNC_TRANS, 15, 32'hFFFFFFFF, 1'b1);
    send_fields(2'd3, 15, 32'hFFFFFFFF, 1'b1);
    send_fields(FUNC_IDENT, 0, 32'h0, 1'b1);
    send_fields(FUNC_LOAD, 5, 32'h00030000, 1'b1);
    send_fields(FUNC_TRANS, 0, 32'h0, 1'b0);

    // Random phases: no idling, then sender idle most of the time, then medium.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 84 : 34;
      for (int m = 0; m < 15; m++) begin
        case ($urandom_range(0, 9))
          0: send_fields(FUNC_IDENT, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
          1: send_fields(FUNC_TRANS, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
          2: send_fields(2'd3, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
          3: send_fields(FUNC_LOAD, $urandom_range(0, 15), rand_value(), $urandom_range(0, 1));
          default: send_matrix();
        endcase
      end
    end
    start <= 1'b0;

    // Drain: wait for all expected elements, then a short tail for stray output.
    while (sb.pending_elems.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_elems.size() == 0)
      $display("tb_matrix4_transform_accumulator: PASS");
    else
      $display("tb_matrix4_transform_accumulator: FAIL");
    $finish;
  end
endmodule
